// ===== rtl/dhc_pkg.sv =====
package dhc_pkg;

  localparam int COEF_W     = 48;
  localparam int HALF_W     = 24;
  localparam int DISP_W     = 16;
  localparam int OUT_W      = 32;
  localparam int IDX_W      = 24;
  localparam int SIZE_W     = 13;
  localparam int SEL_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_COEF   = 18;
  localparam int HOM_COEFS  = 9;
  localparam int PROJ_SHIFT = 16;
  localparam int QUOT_BITS  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COEF_SELECT  = 2'd2,
    REG_COEF_VALUE   = 2'd3
  } cfg_reg_e;

  // multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic mul;
    logic acc;
    logic hi;
  } mac_cmd_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } div_sts_t;

endpackage

// ===== rtl/dhc_mac.sv =====
module dhc_mac #(
  parameter int PW    = 18,
  parameter int ACC_W = 68
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dhc_pkg::mac_cmd_t                   cmd_i,
  input  logic signed [dhc_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [PW-1:0]                pnt_i,
  output logic signed [ACC_W-1:0]             acc_o
);
  import dhc_pkg::*;

  localparam int AW    = HALF_W + 1;
  localparam int PRODW = AW + PW;

  logic signed [AW-1:0]    opa;
  logic signed [PRODW-1:0] prod_d, prod_q;
  logic                    hi_q;
  logic signed [ACC_W-1:0] ext, addend, acc_q;

  // one coefficient half per pass: low half unsigned, high half signed
  assign opa = cmd_i.hi ? $signed({coef_i[COEF_W-1], coef_i[COEF_W-1:HALF_W]})
                        : $signed({1'b0, coef_i[HALF_W-1:0]});
  assign prod_d = opa * pnt_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      hi_q   <= cmd_i.hi;
    end
  end

  assign ext    = $signed({{(ACC_W-PRODW){prod_q[PRODW-1]}}, prod_q});
  assign addend = hi_q ? (ext <<< HALF_W) : ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.clear) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_q + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/dhc_div.sv =====
module dhc_div #(
  parameter int ACC_W = 68
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ACC_W-1:0]            num_i,
  input  logic signed [ACC_W-1:0]            den_i,
  output logic [dhc_pkg::OUT_W-1:0]          res_o,
  output dhc_pkg::div_sts_t                  sts_o
);
  import dhc_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_RUN   = 3'b100
  } dstate_e;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  dstate_e state_q, state_d;
  logic [ACC_W-1:0]     num_mag, den_mag, r_q, d_q;
  logic [QUOT_BITS-1:0] nlo_q, q_q, q_fin;
  logic [4:0]           cnt_q;
  logic                 neg_q, nneg_q, nz_q, dz_q;
  logic [ACC_W:0]       trial, diff;
  logic                 ge;
  logic [OUT_W-1:0]     res_q;
  logic                 done_q, zero_q;

  assign num_mag = num_i[ACC_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[ACC_W-1] ? (~den_i + 1'b1) : den_i;

  assign trial = {r_q, nlo_q[QUOT_BITS-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};
  assign q_fin = {q_q[QUOT_BITS-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      D_IDLE:  if (start_i) state_d = D_CHECK;
      D_CHECK: if (!dz_q && (r_q < d_q)) state_d = D_RUN;
               else state_d = D_IDLE;
      D_RUN:   if (cnt_q == 5'd31) state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        D_IDLE: begin
          cnt_q <= '0;
        end
        D_CHECK: begin
          zero_q <= dz_q;
          if (dz_q) begin
            done_q <= 1'b1;
          end else if (r_q >= d_q) begin
            done_q <= 1'b1;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) done_q <= 1'b1;
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          neg_q  <= num_i[ACC_W-1] ^ den_i[ACC_W-1];
          nneg_q <= num_i[ACC_W-1];
          nz_q   <= num_i != '0;
          dz_q   <= den_i == '0;
          // numerator scaled by 2^16, upper part seeds the remainder
          r_q    <= num_mag >> PROJ_SHIFT;
          nlo_q  <= {num_mag[PROJ_SHIFT-1:0], {(QUOT_BITS-PROJ_SHIFT){1'b0}}};
          d_q    <= den_mag;
          q_q    <= '0;
        end
      end
      D_CHECK: begin
        if (dz_q) begin
          res_q <= nneg_q ? SAT_MIN : (nz_q ? SAT_MAX : '0);
        end else if (r_q >= d_q) begin
          res_q <= neg_q ? SAT_MIN : SAT_MAX;
        end
      end
      D_RUN: begin
        r_q   <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        nlo_q <= {nlo_q[QUOT_BITS-2:0], 1'b0};
        q_q   <= q_fin;
        if (cnt_q == 5'd31) begin
          if (neg_q) begin
            res_q <= (q_fin > SAT_MIN) ? SAT_MIN : (~q_fin + 1'b1);
          end else begin
            res_q <= (q_fin > SAT_MAX) ? SAT_MAX : q_fin;
          end
        end
      end
      default: q_q <= q_q;
    endcase
  end

  assign res_o      = res_q;
  assign sts_o.busy = state_q != D_IDLE;
  assign sts_o.done = done_q;
  assign sts_o.zero = zero_q;

endmodule

// ===== rtl/disparity_homography_correspondence.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid_i/tready_o     tdata: disparity; tuser: masked
// m_axis    out  m_axis_tvalid_o/tready_i     tdata: first_x..pair_index; tuser: degenerate
// cfg       in   cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// an unmasked pixel runs, per homography, three sums of six 25 x PW
// multiply/accumulate passes (MUL then ACC) on the shared multiplier, then two
// divisions on the radix-2 divider
// a masked pixel does not leave the idle state; tready is high only while idle
// the next result waits until the output register is free, a held result
// does not stop the next pixel from being taken
// reset clears counters and control and sets the sizes to 1024 x 768; the coefficient store is not cleared
module disparity_homography_correspondence #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [15:0]                         s_axis_tdata_i,  // disparity
  input  logic                                s_axis_tuser_i,  // masked
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // first_x, first_y, second_x, second_y, pair_index
  output logic [151:0]                        m_axis_tdata_o,
  output logic                                m_axis_tuser_o,  // degenerate
  input  logic                                cfg_we_i,
  input  logic [dhc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dhc_pkg::COEF_W-1:0]          cfg_data_i
);
  import dhc_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int PW    = (((MW + 4) > DISP_W) ? (MW + 4) : DISP_W) + 2;
  localparam int ACC_W = COEF_W + PW + 2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ACC   = 9'b000000100,
    S_STORE = 9'b000001000,
    S_DIVX  = 9'b000010000,
    S_WAITX = 9'b000100000,
    S_DIVY  = 9'b001000000,
    S_WAITY = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SIZE_W-1:0] width_q, height_q;
  logic [SEL_W-1:0]  sel_q;
  logic [COEF_W-1:0] coef_mem [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(1024);
      height_q <= SIZE_W'(768);
      sel_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        REG_COEF_SELECT:  sel_q    <= cfg_data_i[SEL_W-1:0];
        default:          sel_q    <= sel_q;
      endcase
    end
  end

  // coefficient store, selected slot takes each value write while the select is below NUM_COEF
  always_ff @(posedge clk_i) begin
    if (cfg_we_i && (cfg_index_i == REG_COEF_VALUE) && (sel_q < SEL_W'(NUM_COEF))) begin
      coef_mem[sel_q] <= cfg_data_i;
    end
  end

  // effective raster size, zero counts as one, sizes above the maximum are clamped
  logic [31:0] w32, h32;
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  assign w32 = (width_q == '0) ? 32'd1 :
               ((32'(width_q) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_q));
  assign h32 = (height_q == '0) ? 32'd1 :
               ((32'(height_q) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_q));
  assign w_eff = w32[CW:0];
  assign h_eff = h32[RW:0];

  // raster position
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [IDX_W-1:0] emitted_q;
  logic             col_wrap, row_wrap, in_fire;

  assign s_axis_tready_o = state_q == S_IDLE;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign col_wrap = ({1'b0, col_q} + 1'b1) >= w_eff;
  assign row_wrap = ({1'b0, row_q} + 1'b1) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      emitted_q <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
      if (col_wrap && row_wrap) begin
        emitted_q <= '0;
      end else if (!s_axis_tuser_i) begin
        emitted_q <= emitted_q + 1'b1;
      end
    end
  end

  // per-pixel operands, Q.4
  logic signed [PW-1:0] px1_q, px2_q, py_q, px1_d, pnt;
  logic [IDX_W-1:0]     idx_w_q;

  assign px1_d = $signed({{(PW-CW-4){1'b0}}, col_q, 4'b0000});

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px1_q   <= px1_d;
      px2_q   <= px1_d + $signed({{(PW-DISP_W){s_axis_tdata_i[DISP_W-1]}}, s_axis_tdata_i});
      py_q    <= $signed({{(PW-RW-4){1'b0}}, row_q, 4'b0000});
      idx_w_q <= emitted_q;
    end
  end

  // sequencer counters: homography, sum, term, coefficient half
  logic       map_q, half_q;
  logic [1:0] zsel_q, term_q;
  logic [SEL_W-1:0] addr;

  assign addr = (map_q ? SEL_W'(HOM_COEFS) : SEL_W'(0))
              + SEL_W'(zsel_q) * SEL_W'(3) + SEL_W'(term_q);

  always_comb begin
    case (term_q)
      2'd0:    pnt = map_q ? px2_q : px1_q;
      2'd1:    pnt = py_q;
      default: pnt = PW'(16);
    endcase
  end

  mac_cmd_t             mac_cmd;
  logic signed [ACC_W-1:0] acc;

  assign mac_cmd.clear = in_fire || (state_q == S_STORE);
  assign mac_cmd.mul   = state_q == S_MUL;
  assign mac_cmd.acc   = state_q == S_ACC;
  assign mac_cmd.hi    = half_q;

  dhc_mac #(.PW(PW), .ACC_W(ACC_W)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .coef_i ($signed(coef_mem[addr])),
    .pnt_i  (pnt),
    .acc_o  (acc)
  );

  // projective sums of the current homography
  logic signed [ACC_W-1:0] zx_q, zy_q, zw_q;
  logic [OUT_W-1:0]        div_res;
  div_sts_t                div_sts;
  logic                    div_start;

  assign div_start = (state_q == S_DIVX) || (state_q == S_DIVY);

  dhc_div #(.ACC_W(ACC_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((state_q == S_DIVY) ? zy_q : zx_q),
    .den_i   (zw_q),
    .res_o   (div_res),
    .sts_o   (div_sts)
  );

  logic out_free;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire && !s_axis_tuser_i) state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (half_q && (term_q == 2'd2)) ? S_STORE : S_MUL;
      S_STORE: state_d = (zsel_q == 2'd2) ? S_DIVX : S_MUL;
      S_DIVX:  state_d = S_WAITX;
      S_WAITX: if (div_sts.done) state_d = S_DIVY;
      S_DIVY:  state_d = S_WAITY;
      S_WAITY: if (div_sts.done) state_d = map_q ? S_FIN : S_MUL;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      map_q   <= 1'b0;
      half_q  <= 1'b0;
      zsel_q  <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          map_q  <= 1'b0;
          half_q <= 1'b0;
          zsel_q <= '0;
          term_q <= '0;
        end
        S_ACC: begin
          half_q <= ~half_q;
          if (half_q && (term_q != 2'd2)) term_q <= term_q + 2'd1;
        end
        S_STORE: begin
          term_q <= '0;
          half_q <= 1'b0;
          zsel_q <= (zsel_q == 2'd2) ? 2'd0 : zsel_q + 2'd1;
        end
        S_WAITY: begin
          if (div_sts.done) map_q <= 1'b1;
        end
        default: map_q <= map_q;
      endcase
    end
  end

  // results of both homographies
  logic [OUT_W-1:0] fx_q, fy_q, sx_q, sy_q;
  logic             deg_w_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) deg_w_q <= 1'b0;
    if (state_q == S_STORE) begin
      case (zsel_q)
        2'd0:    zx_q <= acc;
        2'd1:    zy_q <= acc;
        default: zw_q <= acc;
      endcase
    end
    if (div_sts.done) begin
      if (div_sts.zero) deg_w_q <= 1'b1;
      if (state_q == S_WAITX) begin
        if (map_q) sx_q <= div_res;
        else fx_q <= div_res;
      end else if (state_q == S_WAITY) begin
        if (map_q) sy_q <= div_res;
        else fy_q <= div_res;
      end
    end
  end

  // output register
  logic         m_valid_q;
  logic [151:0] m_data_q;
  logic         m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == S_FIN) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      m_data_q <= {idx_w_q, sy_q, sx_q, fy_q, fx_q};
      m_user_q <= deg_w_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_sts.busy)
    else $error("divider busy while block idle");

  a_masked_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i) |=> s_axis_tready_o)
    else $error("masked pixel did not return to idle");

  a_unmasked_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("unmasked pixel not processed");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> ((state_q == S_WAITX) || (state_q == S_WAITY)))
    else $error("division finished outside a wait state");
`endif

endmodule
